/* rtl/core/svf_pkg.sv */
// svf_pkg: widths, register codes, microcode word and rounding/saturation helpers
// for the trapezoidal state-variable filter; no dependencies
package svf_pkg;

  // field widths
  localparam int SAMPLE_W     = 24;
  localparam int CH_W         = 3;
  localparam int MODE_W       = 2;
  localparam int G_W          = 23;
  localparam int K_W          = 22;
  localparam int GAIN_W       = 24;
  localparam int STATE_W      = 32;
  localparam int FRAC_W       = 20;

  // channel storage, at most 2**CH_W channels
  localparam int CH_SLOTS = 8;
  localparam int IDX_W    = (CH_SLOTS > 1) ? $clog2(CH_SLOTS) : 1;

  // datapath widths
  localparam int A_W    = 36;            // signal operand of the shared multiplier
  localparam int B_W    = 25;            // coefficient operand, zero extended
  localparam int P_W    = A_W + B_W;     // product
  localparam int RND_W  = P_W - FRAC_W;  // rounded product
  localparam int WIDE_W = RND_W + 1;     // sums before saturation
  localparam int TMP_W  = A_W;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_COEFF  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_COEFF = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = CFG_IDX_W'(3);

  localparam logic [MODE_W-1:0] MODE_LOWPASS  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_HIGHPASS = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_BANDPASS = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_NOTCH    = MODE_W'(3);

  localparam logic [MODE_W-1:0] MODE_RST = MODE_LOWPASS;
  localparam logic [G_W-1:0]    G_RST    = G_W'(82526);
  localparam logic [K_W-1:0]    K_RST    = K_W'(1483134);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(1048576);

  // rounding and saturation constants
  localparam logic signed [P_W-1:0]    RND_HALF = P_W'(64'sd1 <<< (FRAC_W - 1));
  localparam logic signed [WIDE_W-1:0] ST_HI    = WIDE_W'((64'sd1 <<< (STATE_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] ST_LO    = -ST_HI - 1;
  localparam logic signed [WIDE_W-1:0] OUT_HI   = WIDE_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
  localparam logic signed [WIDE_W-1:0] OUT_LO   = -OUT_HI - 1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [G_W-1:0]    g;
    logic [K_W-1:0]    k;
    logic [GAIN_W-1:0] gain;
  } coeff_t;

  // microcode
  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    A_DIFF_IN,   // v0 - v2
    A_V2,
    A_T1_MINUS,  // t1 - round(k*v2)
    A_T1,
    A_RESP       // mode-selected response
  } a_sel_e;

  typedef enum logic [1:0] {
    B_G,
    B_K,
    B_GAIN
  } b_sel_e;

  typedef enum logic [2:0] {
    D_NONE,
    D_T1,
    D_TMP,
    D_T2,
    D_HP,
    D_STATE,
    D_OUT,
    D_BYPASS
  } dst_e;

  typedef enum logic {
    J_NEXT,
    J_BYPASS
  } jmp_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    dst_e            dst;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            fin;
  } ucode_t;

  typedef struct packed {
    logic             load;
    logic             adv;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    ucode_t           uc;
  } dp_ctl_t;

  localparam logic [PC_W-1:0] PC_START  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_BYPASS = PC_W'(8);

  function automatic ucode_t uc_word(input a_sel_e a, input b_sel_e b, input dst_e d,
                                     input jmp_e j, input logic [PC_W-1:0] t,
                                     input logic f);
    ucode_t w;
    w.a_sel  = a;
    w.b_sel  = b;
    w.dst    = d;
    w.jmp    = j;
    w.target = t;
    w.fin    = f;
    return w;
  endfunction

  // filter program, one control word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_W'(0): w = uc_word(A_DIFF_IN,  B_G,    D_NONE,   J_BYPASS, PC_BYPASS, 1'b0);
      PC_W'(1): w = uc_word(A_V2,       B_K,    D_T1,     J_NEXT,   PC_START,  1'b0);
      PC_W'(2): w = uc_word(A_DIFF_IN,  B_G,    D_TMP,    J_NEXT,   PC_START,  1'b0);
      PC_W'(3): w = uc_word(A_T1_MINUS, B_G,    D_NONE,   J_NEXT,   PC_START,  1'b0);
      PC_W'(4): w = uc_word(A_T1,       B_K,    D_T2,     J_NEXT,   PC_START,  1'b0);
      PC_W'(5): w = uc_word(A_DIFF_IN,  B_G,    D_HP,     J_NEXT,   PC_START,  1'b0);
      PC_W'(6): w = uc_word(A_RESP,     B_GAIN, D_STATE,  J_NEXT,   PC_START,  1'b0);
      PC_W'(7): w = uc_word(A_DIFF_IN,  B_G,    D_OUT,    J_NEXT,   PC_START,  1'b1);
      PC_W'(8): w = uc_word(A_DIFF_IN,  B_G,    D_BYPASS, J_NEXT,   PC_START,  1'b1);
      default:  w = uc_word(A_DIFF_IN,  B_G,    D_NONE,   J_NEXT,   PC_START,  1'b1);
    endcase
    return w;
  endfunction

  // floor((p + 2^19) / 2^20)
  function automatic logic signed [RND_W-1:0] round_q20(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] s;
    s = p + RND_HALF;
    return s[P_W-1:FRAC_W];
  endfunction

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] r;
    if (x > ST_HI) begin
      r = ST_HI;
    end else if (x < ST_LO) begin
      r = ST_LO;
    end else begin
      r = x;
    end
    return r[STATE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] r;
    if (x > OUT_HI) begin
      r = OUT_HI;
    end else if (x < OUT_LO) begin
      r = OUT_LO;
    end else begin
      r = x;
    end
    return r[SAMPLE_W-1:0];
  endfunction

endpackage

/* rtl/core/svf_if.sv */
// svf channel interfaces: sample input, sample output and configuration write
// depends on svf_pkg for field widths
interface svf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [svf_pkg::SAMPLE_W-1:0]  sample_in;
  logic        [svf_pkg::CH_W-1:0]      channel;
  logic                                 block_end_in;

  modport source (output valid, sample_in, channel, block_end_in, input ready);
  modport sink   (input valid, sample_in, channel, block_end_in, output ready);
endinterface

interface svf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [svf_pkg::SAMPLE_W-1:0]  sample_out;
  logic        [svf_pkg::CH_W-1:0]      channel_out;
  logic                                 block_end_out;

  modport source (output valid, sample_out, channel_out, block_end_out, input ready);
  modport sink   (input valid, sample_out, channel_out, block_end_out, output ready);
endinterface

interface svf_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [svf_pkg::CFG_IDX_W-1:0]        index;
  logic [svf_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/state_variable_filter_tpt_top.sv */
// state_variable_filter_tpt_top: microcoded trapezoidal state-variable filter
// one input transaction at a time: input stays closed while the eight-step program runs all
//   five products through one shared multiplier (a bypassed channel jumps to the bypass step)
// reset: rst_ni async active low clears sequencer, output valid and all integrator states and
//   loads the coefficient register defaults; no clearing pass, input is ready right after reset
module state_variable_filter_tpt_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  svf_in_if.sink    in_chan_i,
  svf_out_if.source out_chan_o,
  svf_cfg_if.sink   cfg_chan_i
);
  import svf_pkg::*;

  // configuration registers
  coeff_t coeff_q;

  // sequencer
  logic             busy_q;
  logic [PC_W-1:0]  pc_q;
  logic [CH_W-1:0]  ch_q;
  logic             be_q;
  ucode_t           uc;
  logic             bypass;
  logic             slot_free;
  logic             stall;
  logic             finish;
  logic             in_acc;

  // output register
  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic [CH_W-1:0]            out_ch_q;
  logic                       out_be_q;

  dp_ctl_t                    dp_ctl;
  logic signed [SAMPLE_W-1:0] dp_result;

  // config writes always taken; out-of-list indexes are dropped
  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q.mode <= MODE_RST;
      coeff_q.g    <= G_RST;
      coeff_q.k    <= K_RST;
      coeff_q.gain <= GAIN_RST;
    end else if (cfg_chan_i.valid) begin
      case (cfg_chan_i.index)
        REG_FILTER_MODE:   coeff_q.mode <= cfg_chan_i.data[MODE_W-1:0];
        REG_CUTOFF_COEFF:  coeff_q.g    <= cfg_chan_i.data[G_W-1:0];
        REG_DAMPING_COEFF: coeff_q.k    <= cfg_chan_i.data[K_W-1:0];
        REG_OUTPUT_GAIN:   coeff_q.gain <= cfg_chan_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // one item at a time; input ready whenever the program is not running
  assign in_chan_i.ready = !busy_q;
  assign in_acc          = in_chan_i.valid && !busy_q;

  // control word for the current step
  assign uc     = ucode_rom(pc_q);
  assign bypass = int'(ch_q) >= CH_SLOTS;

  // the final step waits only if the output register is still occupied
  assign slot_free = !out_valid_q || out_chan_o.ready;
  assign stall     = uc.fin && !slot_free;
  assign finish    = busy_q && uc.fin && slot_free;

  assign dp_ctl.load   = in_acc;
  assign dp_ctl.adv    = busy_q && !stall;
  assign dp_ctl.rd_idx = in_chan_i.channel[IDX_W-1:0];
  assign dp_ctl.wr_idx = ch_q[IDX_W-1:0];
  assign dp_ctl.uc     = uc;

  svf_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dp_ctl),
    .coeff_i  (coeff_q),
    .sample_i (in_chan_i.sample_in),
    .result_o (dp_result)
  );

  // step counter with the bypass jump at the first step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_START;
    end else if (in_acc) begin
      busy_q <= 1'b1;
      pc_q   <= PC_START;
    end else if (finish) begin
      busy_q <= 1'b0;
      pc_q   <= PC_START;
    end else if (busy_q && !stall) begin
      if (uc.jmp == J_BYPASS && bypass) begin
        pc_q <= uc.target;
      end else begin
        pc_q <= pc_q + PC_W'(1);
      end
    end
  end

  // channel and block-end tags ride along with the item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q <= in_chan_i.channel;
      be_q <= in_chan_i.block_end_in;
    end
  end

  // output register, freed by the downstream transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_sample_q <= dp_result;
      out_ch_q     <= ch_q;
      out_be_q     <= be_q;
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.sample_out    = out_sample_q;
  assign out_chan_o.channel_out   = out_ch_q;
  assign out_chan_o.block_end_out = out_be_q;

endmodule

/* rtl/core/svf_datapath.sv */
// svf_datapath: operand registers, shared multiplier, rounding/saturation and
// per-channel integrator storage; driven by the microcode word; depends on svf_pkg
module svf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  svf_pkg::dp_ctl_t                    ctl_i,
  input  svf_pkg::coeff_t                     coeff_i,
  input  logic signed [svf_pkg::SAMPLE_W-1:0] sample_i,
  output logic signed [svf_pkg::SAMPLE_W-1:0] result_o
);
  import svf_pkg::*;

  logic signed [STATE_W-1:0]  integ_one_q [CH_SLOTS];
  logic signed [STATE_W-1:0]  integ_two_q [CH_SLOTS];

  logic signed [SAMPLE_W-1:0] v0_q;
  logic signed [STATE_W-1:0]  v1_q, v2_q, t1_q, t1_d, t2_q, t2_d;
  logic signed [TMP_W-1:0]    tmp_q, tmp_d;
  logic signed [P_W-1:0]      prod_q, prod_d;

  logic signed [A_W-1:0]      a_op;
  logic signed [B_W-1:0]      b_op;
  logic signed [WIDE_W-1:0]   rnd_w;
  logic signed [STATE_W-1:0]  st1_new, st2_new;

  // operand select
  always_comb begin
    case (ctl_i.uc.a_sel)
      A_DIFF_IN:  a_op = A_W'(v0_q) - A_W'(v2_q);
      A_V2:       a_op = A_W'(v2_q);
      A_T1_MINUS: a_op = A_W'(t1_q) - tmp_q;
      A_T1:       a_op = A_W'(t1_q);
      A_RESP: begin
        case (coeff_i.mode)
          MODE_HIGHPASS: a_op = tmp_q;
          MODE_BANDPASS: a_op = A_W'(t1_q);
          MODE_NOTCH:    a_op = tmp_q + A_W'(t2_q);
          default:       a_op = A_W'(t2_q);
        endcase
      end
      default:    a_op = A_W'(v0_q) - A_W'(v2_q);
    endcase
  end

  always_comb begin
    case (ctl_i.uc.b_sel)
      B_G:     b_op = $signed({{(B_W - G_W){1'b0}}, coeff_i.g});
      B_K:     b_op = $signed({{(B_W - K_W){1'b0}}, coeff_i.k});
      B_GAIN:  b_op = $signed({{(B_W - GAIN_W){1'b0}}, coeff_i.gain});
      default: b_op = $signed({{(B_W - G_W){1'b0}}, coeff_i.g});
    endcase
  end

  assign prod_d = P_W'(a_op) * P_W'(b_op);
  assign rnd_w  = WIDE_W'(round_q20(prod_q));

  // post-multiply updates
  always_comb begin
    t1_d  = t1_q;
    t2_d  = t2_q;
    tmp_d = tmp_q;
    case (ctl_i.uc.dst)
      D_T1:    t1_d  = sat_state(WIDE_W'(v1_q) + rnd_w);
      D_TMP:   tmp_d = rnd_w[TMP_W-1:0];
      D_T2:    t2_d  = sat_state(WIDE_W'(v2_q) + rnd_w);
      D_HP:    tmp_d = TMP_W'(WIDE_W'(v0_q) - rnd_w - WIDE_W'(t2_q));
      default: ;
    endcase
  end

  assign st1_new = sat_state((WIDE_W'(t1_q) <<< 1) - WIDE_W'(v1_q));
  assign st2_new = sat_state((WIDE_W'(t2_q) <<< 1) - WIDE_W'(v2_q));

  assign result_o = (ctl_i.uc.dst == D_BYPASS) ? v0_q : sat_out(rnd_w);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      v0_q <= sample_i;
      v1_q <= integ_one_q[ctl_i.rd_idx];
      v2_q <= integ_two_q[ctl_i.rd_idx];
    end
    if (ctl_i.adv) begin
      prod_q <= prod_d;
      t1_q   <= t1_d;
      t2_q   <= t2_d;
      tmp_q  <= tmp_d;
    end
  end

  // integrator state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CH_SLOTS; i++) begin
        integ_one_q[i] <= '0;
        integ_two_q[i] <= '0;
      end
    end else if (ctl_i.adv && ctl_i.uc.dst == D_STATE) begin
      integ_one_q[ctl_i.wr_idx] <= st1_new;
      integ_two_q[ctl_i.wr_idx] <= st2_new;
    end
  end

endmodule

/* rtl/core/svf_checker.sv */
// svf_checker: port-level assertions for the filter top level, with its bind
// depends on svf_pkg and state_variable_filter_tpt_top
module svf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [svf_pkg::SAMPLE_W-1:0] out_sample_i,
  input logic                                cfg_ready_i
);
  import svf_pkg::*;

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("output changed while stalled");

  // one item in flight: input closes right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready while item in flight");

  // a new result only comes out of a running program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without work in flight");

  // configuration writes are never back-pressured
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config port not ready");

endmodule

bind state_variable_filter_tpt_top svf_checker u_svf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_chan_i.valid),
  .in_ready_i   (in_chan_i.ready),
  .out_valid_i  (out_chan_o.valid),
  .out_ready_i  (out_chan_o.ready),
  .out_sample_i (out_chan_o.sample_out),
  .cfg_ready_i  (cfg_chan_i.ready)
);

/* tb/tb_state_variable_filter_tpt_top.sv */
// tb_state_variable_filter_tpt_top: self-checking bench for the trapezoidal state-variable filter
// needs svf_pkg, the svf_if channel interfaces and state_variable_filter_tpt_top; checks every
// output transaction against an in-bench fixed-point model of the filter
module tb_state_variable_filter_tpt_top;
  timeunit 1ns;
  timeprecision 1ps;

  import svf_pkg::*;

  // cycles allowed after the last result before a register write or the end of the run
  localparam int SETTLE_CYCLES = 12;

  // coefficient extremes and own copies of the register reset values
  localparam int unsigned G_MAX       = (1 << G_W) - 1;
  localparam int unsigned K_MAX       = (1 << K_W) - 1;
  localparam int unsigned GAIN_MAX    = (1 << GAIN_W) - 1;
  localparam int unsigned UNITY_GAIN  = 1 << FRAC_W;
  localparam int unsigned G_AT_RESET  = 82526;
  localparam int unsigned K_AT_RESET  = 1483134;
  localparam int unsigned GAIN_AT_RST = 1048576;

  localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));
  localparam int CH_LAST    = (1 << CH_W) - 1;

  // one audio transaction, used for both the input and the filtered output
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            ch;
    logic                       last;
  } audio_item_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  svf_in_if  in_chan ();
  svf_out_if out_chan ();
  svf_cfg_if cfg_chan ();

  state_variable_filter_tpt_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  // ---------------------------------------------------------------------------
  // filter model: register copies and per-channel integrator states
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]         mode_m;
  logic [G_W-1:0]            g_m;
  logic [K_W-1:0]            k_m;
  logic [GAIN_W-1:0]         gain_m;
  logic signed [STATE_W-1:0] integ1_m [CH_SLOTS];
  logic signed [STATE_W-1:0] integ2_m [CH_SLOTS];

  // stimulus and expectation stores
  audio_item_t samples_to_send[$];
  reg_write_t  reg_writes_to_send[$];
  audio_item_t filtered_expected[$];

  audio_item_t sample_on_bus;
  reg_write_t  write_on_bus;

  int unsigned samples_queued;
  int unsigned results_checked;
  int unsigned reg_writes_queued;
  int unsigned reg_writes_done;
  int unsigned mismatch_count;

  // idling control: sender gap, receiver stall, and a switch per phase
  int send_gap;
  int stall_left;
  bit idling_on;

  // floor((x + 2^19) / 2^20), arithmetic shift floors negative values
  function automatic longint round_half_up(input longint x);
    return (x + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic longint clip(input longint x, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // one filter step: updates the channel state, returns the expected output transaction
  function automatic audio_item_t filter_sample(input audio_item_t it);
    audio_item_t y;
    int unsigned c;
    longint v0, v1, v2;
    longint gc, kc, gainc;
    longint t1, t2, hp, resp;
    y = it;
    c = 32'(it.ch);
    // channels without storage pass the sample straight through
    if (c >= CH_SLOTS) return y;
    v0    = longint'(it.sample);
    v1    = longint'(integ1_m[c]);
    v2    = longint'(integ2_m[c]);
    gc    = longint'(g_m);
    kc    = longint'(k_m);
    gainc = longint'(gain_m);
    t1 = clip(v1 + round_half_up(gc * (v0 - v2)), STATE_W);
    t2 = clip(v2 + round_half_up(gc * (t1 - round_half_up(kc * v2))), STATE_W);
    hp = v0 - round_half_up(kc * t1) - t2;
    integ1_m[c] = STATE_W'(clip(2 * t1 - v1, STATE_W));
    integ2_m[c] = STATE_W'(clip(2 * t2 - v2, STATE_W));
    case (mode_m)
      MODE_HIGHPASS: resp = hp;
      MODE_BANDPASS: resp = t1;
      MODE_NOTCH:    resp = hp + t2;
      default:       resp = t2;
    endcase
    y.sample = SAMPLE_W'(clip(round_half_up(resp * gainc), SAMPLE_W));
    return y;
  endfunction

  // unknown indexes are dropped, data is cut to the register width
  function automatic void apply_reg_write(input reg_write_t w);
    case (w.idx)
      REG_FILTER_MODE:   mode_m = w.data[MODE_W-1:0];
      REG_CUTOFF_COEFF:  g_m    = w.data[G_W-1:0];
      REG_DAMPING_COEFF: k_m    = w.data[K_W-1:0];
      REG_OUTPUT_GAIN:   gain_m = w.data[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // sample driver: the model steps at the edge where the input transaction is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        filtered_expected.push_back(filter_sample(sample_on_bus));
        // a gap right after a transaction lands on a random step of the program
        if (idling_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 19);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          sample_on_bus = samples_to_send.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.sample_in    <= sample_on_bus.sample;
          in_chan.channel      <= sample_on_bus.ch;
          in_chan.block_end_in <= sample_on_bus.last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // register write driver, only fed while the filter is idle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_chan.valid <= 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        apply_reg_write(write_on_bus);
        reg_writes_done++;
      end
      if (!cfg_chan.valid || cfg_chan.ready) begin
        if (reg_writes_to_send.size() > 0) begin
          write_on_bus = reg_writes_to_send.pop_front();
          cfg_chan.valid <= 1'b1;
          cfg_chan.index <= write_on_bus.idx;
          cfg_chan.data  <= write_on_bus.data;
        end else begin
          cfg_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: compares each output transaction with the oldest expectation,
  // and stalls the output in random bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : out_monitor
    audio_item_t want;
    if (!rst_ni) begin
      out_chan.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (filtered_expected.size() == 0) begin
          $error("unexpected output transaction: sample_out %0d channel_out %0d",
                 out_chan.sample_out, out_chan.channel_out);
          mismatch_count++;
        end else begin
          want = filtered_expected.pop_front();
          results_checked++;
          if (out_chan.sample_out !== want.sample) begin
            $error("sample_out: expected %0d, actual %0d", want.sample, out_chan.sample_out);
            mismatch_count++;
          end
          if (out_chan.channel_out !== want.ch) begin
            $error("channel_out: expected %0d, actual %0d", want.ch, out_chan.channel_out);
            mismatch_count++;
          end
          if (out_chan.block_end_out !== want.last) begin
            $error("block_end_out: expected %0d, actual %0d", want.last,
                   out_chan.block_end_out);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
        // this cycle counts as the first of the burst
        stall_left = $urandom_range(0, 18);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_sample(input int value, input int ch, input bit last);
    audio_item_t it;
    it.sample = SAMPLE_W'(value);
    it.ch     = CH_W'(ch);
    it.last   = last;
    samples_to_send.push_back(it);
    samples_queued++;
  endtask

  // sample levels: rails, quiet signal, and the full range
  function automatic int pick_level();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return int'($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom) >>> (32 - SAMPLE_W);
    endcase
  endfunction

  // mostly frames of channels 0..n-1 closed by a block end, some stray transactions
  task automatic add_random_samples(input int count);
    int n;
    int width;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 7) == 0) begin
        add_sample(pick_level(), $urandom_range(0, CH_LAST), 1'($urandom_range(0, 1)));
        n++;
      end else begin
        width = $urandom_range(1, CH_SLOTS);
        for (int c = 0; c < width; c++) begin
          add_sample(pick_level(), c, c == width - 1);
          n++;
        end
      end
    end
  endtask

  // bits above the register width carry junk, the block must drop them
  task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                               input int width);
    reg_write_t w;
    w.idx  = idx;
    w.data = ($urandom << width) | value;
    reg_writes_to_send.push_back(w);
    reg_writes_queued++;
  endtask

  // waits for every transaction to finish, then lets the pipeline settle
  task automatic wait_idle();
    while (results_checked != samples_queued || reg_writes_done != reg_writes_queued)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_filter(input logic [MODE_W-1:0] mode, input int unsigned g,
                            input int unsigned k, input int unsigned gain);
    add_reg_write(REG_FILTER_MODE, 32'(mode), MODE_W);
    // a write to an index with no register behind it
    add_reg_write(CFG_IDX_W'($urandom_range(4, (1 << CFG_IDX_W) - 1)), $urandom, 0);
    add_reg_write(REG_CUTOFF_COEFF, g, G_W);
    add_reg_write(REG_DAMPING_COEFF, k, K_W);
    add_reg_write(REG_OUTPUT_GAIN, gain, GAIN_W);
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned g_pick;
    int unsigned gain_pick;

    // model state after reset
    mode_m = MODE_LOWPASS;
    g_m    = G_W'(G_AT_RESET);
    k_m    = K_W'(K_AT_RESET);
    gain_m = GAIN_W'(GAIN_AT_RST);
    for (int c = 0; c < CH_SLOTS; c++) begin
      integ1_m[c] = '0;
      integ2_m[c] = '0;
    end
    samples_queued    = 0;
    results_checked   = 0;
    reg_writes_queued = 0;
    reg_writes_done   = 0;
    mismatch_count    = 0;
    idling_on         = 1'b1;

    // every input known from time zero
    in_chan.valid        = 1'b0;
    in_chan.sample_in    = '0;
    in_chan.channel      = '0;
    in_chan.block_end_in = 1'b0;
    out_chan.ready       = 1'b0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.index       = '0;
    cfg_chan.data        = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // reset coefficients: rails, zero, single lsb, alternating bit patterns
    add_sample(SAMPLE_MAX, 0, 1'b0);
    add_sample(SAMPLE_MAX, 0, 1'b0);
    add_sample(SAMPLE_MIN, 0, 1'b0);
    add_sample(SAMPLE_MIN, 0, 1'b0);
    add_sample(0, 0, 1'b0);
    add_sample(1, CH_LAST, 1'b0);
    add_sample(-1, CH_LAST, 1'b1);
    add_sample(32'h555555, 3, 1'b0);
    add_sample(32'hAAAAAA, 3, 1'b0);
    add_sample(SAMPLE_MAX, 5, 1'b1);
    add_random_samples(40);
    wait_idle();

    // all coefficients at their maximum, drives states and output into saturation
    set_filter(MODE_LOWPASS, G_MAX, K_MAX, GAIN_MAX);
    add_sample(SAMPLE_MAX, 1, 1'b0);
    add_sample(SAMPLE_MAX, 1, 1'b0);
    add_sample(SAMPLE_MAX, 1, 1'b0);
    add_sample(SAMPLE_MIN, 1, 1'b0);
    add_sample(SAMPLE_MIN, 1, 1'b0);
    add_sample(SAMPLE_MAX, 2, 1'b1);
    add_random_samples(40);
    wait_idle();

    // all coefficients zero
    set_filter(MODE_HIGHPASS, 0, 0, 0);
    add_sample(SAMPLE_MAX, 0, 1'b0);
    add_sample(SAMPLE_MIN, 6, 1'b1);
    add_random_samples(40);
    wait_idle();

    // slowest cutoff, heaviest damping, full gain
    set_filter(MODE_BANDPASS, 1, K_MAX, GAIN_MAX);
    add_sample(SAMPLE_MAX, 4, 1'b0);
    add_sample(SAMPLE_MIN, 4, 1'b1);
    add_random_samples(40);
    wait_idle();

    // no damping, widest cutoff, unity gain
    set_filter(MODE_NOTCH, G_MAX, 0, UNITY_GAIN);
    add_sample(SAMPLE_MAX, CH_LAST, 1'b0);
    add_sample(SAMPLE_MAX, CH_LAST, 1'b0);
    add_sample(SAMPLE_MIN, CH_LAST, 1'b1);
    add_random_samples(40);
    wait_idle();

    // random settings, some with idling switched off
    for (int p = 0; p < 6; p++) begin
      idling_on = ($urandom_range(0, 3) != 0);
      // half the time audio-band cutoffs up to unity, otherwise anything
      g_pick    = ($urandom_range(0, 1) == 0) ? $urandom_range(1000, UNITY_GAIN)
                                              : $urandom_range(0, G_MAX);
      gain_pick = ($urandom_range(0, 2) == 0) ? $urandom_range(0, GAIN_MAX)
                                              : $urandom_range(0, 4 * UNITY_GAIN);
      set_filter(MODE_W'(p), g_pick, $urandom_range(0, K_MAX), gain_pick);
      add_random_samples(45);
      wait_idle();
    end

    // last part of the run without any idling
    idling_on = 1'b0;
    set_filter(MODE_NOTCH, $urandom_range(1000, UNITY_GAIN), K_AT_RESET, UNITY_GAIN);
    add_random_samples(50);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
